@@ sv/magnetometer_calibration_session_grader_core_defines.svh @@
// Assertion macros for the magnetometer calibration session grader.
// Used by the top level only; no other dependencies.
`ifndef MAGNETOMETER_CALIBRATION_SESSION_GRADER_CORE_DEFINES_SVH
`define MAGNETOMETER_CALIBRATION_SESSION_GRADER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define MCG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define MCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ sv/mcg_pkg.sv @@
// Package for the magnetometer calibration session grader: types, codes, constants.
// No dependencies.
`default_nettype none
package mcg_pkg;
   localparam int COUNT_BITS_DEF = 20;
   localparam int OCTANT_START = 40;
   localparam int DIV_BITS = 13;

   typedef enum logic [1:0] {OP_SAMPLE = 2'd0, OP_START = 2'd1, OP_CANCEL = 2'd2} opcode_type;
   typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_RUN = 2'd1, PH_READY = 2'd2,
                             PH_CANCEL = 2'd3} phase_type;
   typedef enum logic [2:0] {CSR_S1 = 3'd0, CSR_S2 = 3'd1, CSR_S3 = 3'd2, CSR_P1 = 3'd3,
                             CSR_P2 = 3'd4, CSR_P3 = 3'd5} csr_index_type;
   typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_SUM, ST_GRADE, ST_OUT} seq_state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [12:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

@@ sv/mcg_divider.sv @@
// Restoring divider for the balance ratio, one quotient bit per cycle.
// Depends on mcg_pkg.
`default_nettype none
module mcg_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mcg_pkg::div_req_type req,
   output mcg_pkg::div_rsp_type    rsp
);
   logic [28:0] rem_ff, rem_in;
   logic [12:0] quo_ff, quo_in;
   logic [12:0] mask_ff, mask_in;
   logic [15:0] dvs_ff, dvs_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [29:0] trial;

   // Quotient fits 13 bits since smallest <= largest gives ratio <= 6400.
   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; mask_in = mask_ff; dvs_in = dvs_ff;
      busy_in = busy_ff; done_in = 1'b0; cnt_in = cnt_ff;
      trial = 30'(rem_ff) - (30'(dvs_ff) << cnt_ff);
      if (req.start) begin
         rem_in = req.dividend[28:0]; dvs_in = req.divisor; quo_in = '0;
         busy_in = 1'b1; cnt_in = 4'(mcg_pkg::DIV_BITS - 1);
      end else if (busy_ff) begin
         if (!trial[29]) begin
            rem_in = trial[28:0];
            quo_in = quo_ff | (13'd1 << cnt_ff);
         end
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0; done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
      mask_in = quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      mask_ff <= mask_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = mask_ff;
endmodule
`default_nettype wire

@@ sv/magnetometer_calibration_session_grader_core.sv @@
// Magnetometer hard-iron calibration session grader, top level.
// A sample item that takes effect is held, then passes through the 13-step divider,
// the axis sums and the grade step before its result item is presented; start,
// cancel and ignored items present theirs the next cycle.
// No new item is taken until the result item of the last one has been taken.
// Reset (synchronous, active high) clears the session to idle and loads defaults.
`default_nettype none
`include "magnetometer_calibration_session_grader_core_defines.svh"
module magnetometer_calibration_session_grader_core #(
   parameter int COUNT_BITS = mcg_pkg::COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic signed [15:0] req_sample_x,
   input  wire logic signed [15:0] req_sample_y,
   input  wire logic signed [15:0] req_sample_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_accepted,
   output logic [1:0]       rsp_session_state,
   output logic [1:0]       rsp_quality,
   output logic [6:0]       rsp_progress,
   output logic [19:0]      rsp_sample_count,
   output logic [3:0]       rsp_covered_octants,
   output logic signed [15:0] rsp_center_x,
   output logic signed [15:0] rsp_center_y,
   output logic signed [15:0] rsp_center_z,
   output logic [15:0]      rsp_span_smallest,
   output logic [15:0]      rsp_span_largest,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_data
);
   // Threshold registers.
   logic [19:0] s1_ff, s2_ff, s3_ff;
   logic [15:0] p1_ff, p2_ff, p3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 20'd100; s2_ff <= 20'd300; s3_ff <= 20'd600;
         p1_ff <= 16'd200; p2_ff <= 16'd400; p3_ff <= 16'd800;
      end else if (csr_write) begin
         unique case (csr_index)
            mcg_pkg::CSR_S1: s1_ff <= csr_data;
            mcg_pkg::CSR_S2: s2_ff <= csr_data;
            mcg_pkg::CSR_S3: s3_ff <= csr_data;
            mcg_pkg::CSR_P1: p1_ff <= csr_data[15:0];
            mcg_pkg::CSR_P2: p2_ff <= csr_data[15:0];
            mcg_pkg::CSR_P3: p3_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Session statistics.
   mcg_pkg::phase_type phase_ff, phase_in;
   mcg_pkg::seq_state_type st_ff, st_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic signed [15:0] lo_ff [3], hi_ff [3], lo_in [3], hi_in [3];
   logic [7:0] oct_ff, oct_in;
   logic [1:0] grade_ff, grade_in;
   logic [6:0] pct_ff, pct_in;
   logic       acc_ff, acc_in;
   logic [16:0] span [3];
   logic [15:0] mn, mx;
   logic [3:0] noct;
   logic signed [16:0] pair [3];
   logic signed [16:0] cen [3];
   logic [15:0] sm, sc;
   mcg_pkg::div_req_type dreq;
   mcg_pkg::div_rsp_type drsp;
   logic [12:0] bal_ff, bal_in;
   logic [18:0] sum_ff, sum_in;
   logic [1:0]  ax_ff, ax_in;
   logic [10:0] sat;
   logic [9:0] csat;
   logic [12:0] bterm;
   logic [18:0] p;
   logic [31:0] prod5;
   logic [39:0] prod45;
   logic       hold_ff, hold_in;
   logic       full;
   logic [2:0] o;
   logic signed [15:0] v [3];
   logic ready_now;
   logic [1:0] g;
   // Held sample for octant marking.
   logic signed [15:0] sv_ff [3];

   assign v[0] = req_sample_x;
   assign v[1] = req_sample_y;
   assign v[2] = req_sample_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         span[i] = 17'(hi_ff[i]) - 17'(lo_ff[i]);
         pair[i] = 17'(lo_ff[i]) + 17'(hi_ff[i]);
         // Adding the sign bit before the arithmetic shift rounds toward zero.
         cen[i] = (pair[i] + $signed(17'(pair[i][16]))) >>> 1;
      end
      mn = span[0][15:0]; mx = span[0][15:0];
      for (int i = 1; i < 3; i++) begin
         if (span[i][15:0] < mn) mn = span[i][15:0];
         if (span[i][15:0] > mx) mx = span[i][15:0];
      end
      noct = '0;
      for (int i = 0; i < 8; i++) noct = noct + 4'(oct_ff[i]);
   end

   assign full = &cnt_ff;
   // The input waits while a sample is processed and while a result item is pending.
   assign req_ready = (st_ff == mcg_pkg::ST_IDLE) && !hold_ff && !out_ff;
   assign dreq.start = (st_ff == mcg_pkg::ST_IDLE) && hold_ff;
   assign dreq.dividend = 32'(mn) * 32'd6400;
   assign dreq.divisor = mx;

   mcg_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Sequencer: next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         mcg_pkg::ST_IDLE:  if (hold_ff) st_in = mcg_pkg::ST_DIV;
         mcg_pkg::ST_DIV:   if (drsp.done) st_in = mcg_pkg::ST_SUM;
         mcg_pkg::ST_SUM:   if (ax_ff == 2'd3) st_in = mcg_pkg::ST_GRADE;
         mcg_pkg::ST_GRADE: st_in = mcg_pkg::ST_OUT;
         mcg_pkg::ST_OUT:   if (rsp_ready) st_in = mcg_pkg::ST_IDLE;
         default:           st_in = mcg_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: datapath.
   always_comb begin
      phase_in = phase_ff; cnt_in = cnt_ff; oct_in = oct_ff; grade_in = grade_ff;
      pct_in = pct_ff; acc_in = acc_ff; bal_in = bal_ff; sum_in = sum_ff; ax_in = ax_ff;
      hold_in = hold_ff;
      lo_in = lo_ff; hi_in = hi_ff;
      o = '0; sat = '0; csat = '0; bterm = '0; p = '0; ready_now = 1'b0; g = '0;
      prod5 = '0; prod45 = '0;
      if (st_ff == mcg_pkg::ST_IDLE && req_valid && req_ready) begin
         acc_in = 1'b0;
         unique case (req_opcode)
            mcg_pkg::OP_SAMPLE: if (phase_ff == mcg_pkg::PH_RUN ||
                                    phase_ff == mcg_pkg::PH_READY) begin
               acc_in = 1'b1; hold_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  if (cnt_ff == '0 || v[i] < lo_ff[i]) lo_in[i] = v[i];
                  if (cnt_ff == '0 || v[i] > hi_ff[i]) hi_in[i] = v[i];
               end
               if (!full) cnt_in = cnt_ff + COUNT_BITS'(1);
            end
            mcg_pkg::OP_START: if (!(phase_ff == mcg_pkg::PH_RUN ||
                                     phase_ff == mcg_pkg::PH_READY)) begin
               acc_in = 1'b1; phase_in = mcg_pkg::PH_RUN; cnt_in = '0; oct_in = '0;
               grade_in = '0; pct_in = '0;
               for (int i = 0; i < 3; i++) begin lo_in[i] = '0; hi_in[i] = '0; end
            end
            mcg_pkg::OP_CANCEL: if (phase_ff == mcg_pkg::PH_RUN ||
                                    phase_ff == mcg_pkg::PH_READY) begin
               acc_in = 1'b1; phase_in = mcg_pkg::PH_CANCEL;
            end
            default: ;
         endcase
      end
      // Octant marking uses the updated envelope and the held sample.
      if (dreq.start) begin
         hold_in = 1'b0;
         if (COUNT_BITS'(mcg_pkg::OCTANT_START) <= cnt_ff) begin
            for (int i = 0; i < 3; i++)
               o[i] = (17'(sv_ff[i]) >= cen[i]) ? 1'b1 : 1'b0;
            oct_in = oct_ff | (8'd1 << o);
         end
         csat = (cnt_ff > COUNT_BITS'(600)) ? 10'd600 : cnt_ff[9:0];
         // Division by five as a reciprocal multiplication, exact below 2^16.
         prod5 = 32'({csat, 6'd0}) * 32'd52429;
         sum_in = 19'(prod5 >> 18);
         ax_in = '0;
      end
      if (st_ff == mcg_pkg::ST_DIV && drsp.done)
         bal_in = (mx == '0) ? 13'd0 : drsp.quotient;
      if (st_ff == mcg_pkg::ST_SUM) begin
         if (ax_ff == 2'd3) begin
            bterm = (bal_ff > 13'd3840) ? 13'd3840 : bal_ff;
            sum_in = sum_ff + 19'(bterm) + 19'(noct) * 19'd480;
         end else begin
            sat = (span[ax_ff][15:0] > 16'd1200) ? 11'd1200 : span[ax_ff][10:0];
            // Division by 45 as a reciprocal multiplication, exact for these spans.
            prod45 = 40'({sat, 7'd0}) * 40'd372828;
            sum_in = sum_ff + 19'(prod45 >> 24);
            ax_in = ax_ff + 2'd1;
         end
      end
      if (st_ff == mcg_pkg::ST_GRADE) begin
         if (32'(cnt_ff) < 32'(s1_ff) || mn < p1_ff) g = 2'd0;
         else if (32'(cnt_ff) < 32'(s2_ff) || mn < p2_ff || mx == 16'd0 ||
                  ({2'b0, mn} << 2) < 18'(mx) || noct < 4'd3) g = 2'd1;
         else if (32'(cnt_ff) < 32'(s3_ff) || mn < p3_ff ||
                  ({1'b0, mn} << 1) < 17'(mx) || noct < 4'd6) g = 2'd2;
         else g = 2'd3;
         grade_in = g;
         ready_now = g >= 2'd2 && 32'(cnt_ff) >= 32'(s2_ff) && mn >= p2_ff;
         p = (sum_ff + 19'd128) >> 8;
         if (ready_now) begin
            pct_in = 7'd100; phase_in = mcg_pkg::PH_READY;
         end else begin
            pct_in = (p > 19'd99) ? 7'd99 : p[6:0];
            if (phase_ff == mcg_pkg::PH_READY) phase_in = mcg_pkg::PH_RUN;
         end
      end
   end

   logic       out_ff, out_in;
   always_comb begin
      out_in = out_ff;
      if (st_ff == mcg_pkg::ST_IDLE && req_valid && req_ready && !hold_in) out_in = 1'b1;
      else if (out_ff && rsp_ready) out_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mcg_pkg::PH_IDLE; st_ff <= mcg_pkg::ST_IDLE; cnt_ff <= '0;
         oct_ff <= '0; grade_ff <= '0; pct_ff <= '0; hold_ff <= 1'b0; out_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin lo_ff[i] <= '0; hi_ff[i] <= '0; end
      end else begin
         phase_ff <= phase_in; st_ff <= st_in; cnt_ff <= cnt_in; oct_ff <= oct_in;
         grade_ff <= grade_in; pct_ff <= pct_in; hold_ff <= hold_in; out_ff <= out_in;
         lo_ff <= lo_in; hi_ff <= hi_in;
      end
      acc_ff <= acc_in; bal_ff <= bal_in; sum_ff <= sum_in; ax_ff <= ax_in;
      if (req_valid && req_ready) sv_ff <= v;
   end

   assign sm = 16'(cen[0]);
   assign sc = 16'(cen[2]);
   assign rsp_valid = (st_ff == mcg_pkg::ST_OUT) || out_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_session_state = phase_ff;
   assign rsp_quality = grade_ff;
   assign rsp_progress = pct_ff;
   assign rsp_sample_count = (COUNT_BITS > 20 && (cnt_ff >> 20) != 0) ? 20'hFFFFF
                             : 20'(cnt_ff);
   assign rsp_covered_octants = noct;
   assign rsp_center_x = sm;
   assign rsp_center_y = 16'(cen[1]);
   assign rsp_center_z = sc;
   assign rsp_span_smallest = mn;
   assign rsp_span_largest = mx;

   `MCG_ASSERT_IMP(a_ready_busy, clock, reset, st_ff != mcg_pkg::ST_IDLE, !req_ready,
                   "input taken while sequencer busy")
   `MCG_ASSERT_IMP(a_pct_range, clock, reset, rsp_valid, rsp_progress <= 7'd100,
                   "progress beyond 100")
   `MCG_ASSERT_NEXT(a_ready_full, clock, reset,
                    st_ff == mcg_pkg::ST_GRADE && phase_in == mcg_pkg::PH_READY,
                    pct_ff == 7'd100, "ready session without full progress")
endmodule
`default_nettype wire

@@ dv/magnetometer_calibration_session_grader_core_tb.sv @@
// Self-checking testbench for the magnetometer calibration session grader.
// Depends on mcg_pkg and the magnetometer_calibration_session_grader_core RTL.
`timescale 1ns / 100ps
`default_nettype none
module magnetometer_calibration_session_grader_core_tb;

   // The opcode value that the block must ignore.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Indexes beyond the register list; writes to them must have no effect.
   localparam logic [2:0] CSR_NONE = 3'd6;
   localparam logic [2:0] CSR_NONE_TOP = 3'd7;
   localparam int unsigned COUNT_FULL = (1 << mcg_pkg::COUNT_BITS_DEF) - 1;
   // A margin above the time that a sample item occupies the block.
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRESSURE_CYCLES = 300;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  session_state;
      logic [1:0]  quality;
      logic [6:0]  progress;
      logic [19:0] sample_count;
      logic [3:0]  covered_octants;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] center_z;
      logic [15:0] span_smallest;
      logic [15:0] span_largest;
   } grade_report_type;

   typedef struct {
      logic [1:0]         op;
      int                 x;
      int                 y;
      int                 z;
      bit                 typed;
      bit                 acc;
      mcg_pkg::phase_type st;
      int unsigned        cnt;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic signed [15:0] req_sample_x;
   logic signed [15:0] req_sample_y;
   logic signed [15:0] req_sample_z;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic [1:0]  rsp_session_state;
   logic [1:0]  rsp_quality;
   logic [6:0]  rsp_progress;
   logic [19:0] rsp_sample_count;
   logic [3:0]  rsp_covered_octants;
   logic signed [15:0] rsp_center_x;
   logic signed [15:0] rsp_center_y;
   logic signed [15:0] rsp_center_z;
   logic [15:0] rsp_span_smallest;
   logic [15:0] rsp_span_largest;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [19:0] csr_data;

   magnetometer_calibration_session_grader_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_sample_x(req_sample_x), .req_sample_y(req_sample_y),
      .req_sample_z(req_sample_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_accepted(rsp_accepted),
      .rsp_session_state(rsp_session_state), .rsp_quality(rsp_quality),
      .rsp_progress(rsp_progress), .rsp_sample_count(rsp_sample_count),
      .rsp_covered_octants(rsp_covered_octants),
      .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .rsp_center_z(rsp_center_z),
      .rsp_span_smallest(rsp_span_smallest), .rsp_span_largest(rsp_span_largest),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // The testbench's own copy of the thresholds and of the session.
   int unsigned min_count [3];
   int unsigned min_span [3];
   mcg_pkg::phase_type sess_phase;
   int unsigned sess_count;
   int          env_low [3];
   int          env_high [3];
   logic [7:0]  octant_mask;
   logic [1:0]  sess_grade;
   int unsigned sess_percent;

   grade_report_type pending_reports [$];
   int errors = 0;
   int results_checked = 0;
   int items_sent = 0;
   int ready_reports = 0;
   int grade_three_reports = 0;
   bit calm = 0;
   bit hold_results = 0;

   initial begin
      clock = 1'b0;
   end
   always #1 clock = ~clock;

   function automatic int unsigned octants_in(input logic [7:0] m);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 8; i++) begin
         n += m[i];
      end
      return n;
   endfunction

   function automatic int unsigned narrowest_span();
      int unsigned mn;
      mn = env_high[0] - env_low[0];
      for (int i = 1; i < 3; i++) begin
         if (env_high[i] - env_low[i] < mn) mn = env_high[i] - env_low[i];
      end
      return mn;
   endfunction

   function automatic int unsigned widest_span();
      int unsigned mx;
      mx = env_high[0] - env_low[0];
      for (int i = 1; i < 3; i++) begin
         if (env_high[i] - env_low[i] > mx) mx = env_high[i] - env_low[i];
      end
      return mx;
   endfunction

   function automatic void clear_envelope();
      sess_count = 0;
      for (int i = 0; i < 3; i++) begin
         env_low[i] = 0;
         env_high[i] = 0;
      end
      octant_mask = '0;
      sess_grade = 2'd0;
      sess_percent = 0;
   endfunction

   // Regrades the session: quality from the thresholds, then progress in
   // 1/256 steps, and readiness from both.
   function automatic void regrade();
      int unsigned mn, mx, oct, s, b;
      int unsigned total;
      bit quarter_low, half_low, is_ready;
      mn = narrowest_span();
      mx = widest_span();
      oct = octants_in(octant_mask);
      quarter_low = (mx == 0) || (4 * mn < mx);
      half_low = (mx == 0) || (2 * mn < mx);
      if (sess_count < min_count[0] || mn < min_span[0])
         sess_grade = 2'd0;
      else if (sess_count < min_count[1] || mn < min_span[1] || quarter_low || oct < 3)
         sess_grade = 2'd1;
      else if (sess_count < min_count[2] || mn < min_span[2] || half_low || oct < 6)
         sess_grade = 2'd2;
      else
         sess_grade = 2'd3;

      total = ((sess_count > 600) ? 600 : sess_count) * 64 / 5;
      for (int i = 0; i < 3; i++) begin
         s = env_high[i] - env_low[i];
         if (s > 1200) s = 1200;
         total += s * 128 / 45;
      end
      if (mx != 0) begin
         b = mn * 6400 / mx;
         total += (b > 3840) ? 3840 : b;
      end
      total += oct * 480;
      sess_percent = (total + 128) >> 8;

      is_ready = sess_grade >= 2'd2 && sess_count >= min_count[1] && mn >= min_span[1];
      if (is_ready) begin
         sess_percent = 100;
         sess_phase = mcg_pkg::PH_READY;
      end else begin
         if (sess_percent > 99) sess_percent = 99;
         if (sess_phase == mcg_pkg::PH_READY) sess_phase = mcg_pkg::PH_RUN;
      end
   endfunction

   function automatic void absorb_sample(input int v [3]);
      logic [2:0] o;
      for (int i = 0; i < 3; i++) begin
         if (sess_count == 0) begin
            env_low[i] = v[i];
            env_high[i] = v[i];
         end else begin
            if (v[i] < env_low[i]) env_low[i] = v[i];
            if (v[i] > env_high[i]) env_high[i] = v[i];
         end
      end
      if (sess_count < COUNT_FULL) sess_count++;
      if (sess_count >= mcg_pkg::OCTANT_START) begin
         for (int i = 0; i < 3; i++) begin
            o[i] = v[i] >= (env_low[i] + env_high[i]) / 2;
         end
         octant_mask[o] = 1'b1;
      end
      regrade();
   endfunction

   // Applies one event to the session copy and returns the report it gives.
   function automatic grade_report_type grade_event(input logic [1:0] op,
                                                    input int x, input int y, input int z);
      grade_report_type r;
      bit active;
      int v [3];
      active = sess_phase == mcg_pkg::PH_RUN || sess_phase == mcg_pkg::PH_READY;
      r.accepted = 1'b0;
      if (op == mcg_pkg::OP_SAMPLE && active) begin
         v[0] = x;
         v[1] = y;
         v[2] = z;
         absorb_sample(v);
         r.accepted = 1'b1;
      end else if (op == mcg_pkg::OP_START && !active) begin
         clear_envelope();
         sess_phase = mcg_pkg::PH_RUN;
         r.accepted = 1'b1;
      end else if (op == mcg_pkg::OP_CANCEL && active) begin
         sess_phase = mcg_pkg::PH_CANCEL;
         r.accepted = 1'b1;
      end
      r.session_state = sess_phase;
      r.quality = sess_grade;
      r.progress = 7'(sess_percent);
      r.sample_count = 20'(sess_count);
      r.covered_octants = 4'(octants_in(octant_mask));
      r.center_x = 16'((env_low[0] + env_high[0]) / 2);
      r.center_y = 16'((env_low[1] + env_high[1]) / 2);
      r.center_z = 16'((env_low[2] + env_high[2]) / 2);
      r.span_smallest = 16'(narrowest_span());
      r.span_largest = 16'(widest_span());
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      errors++;
      if (errors <= 30)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
   endtask

   // Offers one item, waits for its acceptance and records the expected report.
   // Typed rows override the fields that are read straight off the behaviour.
   task automatic send_item(input logic [1:0] op, input int x, input int y, input int z,
                            input bit typed = 0, input bit t_acc = 0,
                            input mcg_pkg::phase_type t_st = mcg_pkg::PH_IDLE,
                            input int unsigned t_cnt = 0);
      grade_report_type r;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_opcode = op;
      req_sample_x = 16'(x);
      req_sample_y = 16'(y);
      req_sample_z = 16'(z);
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      r = grade_event(op, x, y, z);
      if (typed) begin
         r.accepted = t_acc;
         r.session_state = t_st;
         r.sample_count = 20'(t_cnt);
      end
      pending_reports.push_back(r);
      items_sent++;
      @(negedge clock);
   endtask

   // Lets every outstanding report arrive, and the block settle, before a
   // register is touched.
   task automatic write_threshold(input logic [2:0] idx, input int unsigned value);
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = 20'(value);
      @(negedge clock);
      csr_write = 1'b0;
      if (idx <= mcg_pkg::CSR_S3) min_count[idx] = value & 20'hFFFFF;
      else if (idx <= mcg_pkg::CSR_P3) min_span[idx - mcg_pkg::CSR_P1] = value & 16'hFFFF;
   endtask

   task automatic load_thresholds(input int unsigned c1, input int unsigned c2,
                                  input int unsigned c3, input int unsigned s1,
                                  input int unsigned s2, input int unsigned s3);
      write_threshold(mcg_pkg::CSR_S1, c1);
      write_threshold(mcg_pkg::CSR_S2, c2);
      write_threshold(mcg_pkg::CSR_S3, c3);
      write_threshold(mcg_pkg::CSR_P1, s1);
      write_threshold(mcg_pkg::CSR_P2, s2);
      write_threshold(mcg_pkg::CSR_P3, s3);
   endtask

   // One session: a start, then mostly samples scattered around a random
   // hard-iron offset, with the odd stray event or out-of-range reading.
   task automatic run_session(input int n, input int amp, input bit squash);
      int cx, cy, cz, pick;
      cx = int'($urandom_range(0, 8000)) - 4000;
      cy = int'($urandom_range(0, 8000)) - 4000;
      cz = int'($urandom_range(0, 8000)) - 4000;
      send_item(mcg_pkg::OP_START, 0, 0, 0);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            send_item(2'($urandom_range(0, 3)), int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768);
         else if (pick < 5)
            send_item(mcg_pkg::OP_SAMPLE, int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768);
         else
            send_item(mcg_pkg::OP_SAMPLE, cx + int'($urandom_range(0, 2 * amp)) - amp,
                      cy + int'($urandom_range(0, 2 * amp)) - amp,
                      cz + int'($urandom_range(0, (squash ? 2 : 20) * amp / 10)) -
                      (squash ? amp / 5 : amp));
      end
      if ($urandom_range(0, 1) == 0) send_item(mcg_pkg::OP_CANCEL, 0, 0, 0);
   endtask

   // Receiver: random stall bursts, one long hold-off on request, none at the end.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_ready = 1'b0;
            repeat (PRESSURE_CYCLES) @(negedge clock);
            hold_results = 1'b0;
            rsp_ready = 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Each report is compared with the oldest expectation.
   always @(posedge clock) begin
      grade_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected report", 1, 0);
         end else begin
            want = pending_reports.pop_front();
            results_checked++;
            if (want.session_state == mcg_pkg::PH_READY) ready_reports++;
            if (want.quality == 2'd3) grade_three_reports++;
            if (rsp_accepted !== want.accepted)
               report_mismatch("accepted", rsp_accepted, want.accepted);
            if (rsp_session_state !== want.session_state)
               report_mismatch("session_state", rsp_session_state, want.session_state);
            if (rsp_quality !== want.quality)
               report_mismatch("quality", rsp_quality, want.quality);
            if (rsp_progress !== want.progress)
               report_mismatch("progress", rsp_progress, want.progress);
            if (rsp_sample_count !== want.sample_count)
               report_mismatch("sample_count", rsp_sample_count, want.sample_count);
            if (rsp_covered_octants !== want.covered_octants)
               report_mismatch("covered_octants", rsp_covered_octants, want.covered_octants);
            if (rsp_center_x !== want.center_x)
               report_mismatch("center_x", rsp_center_x, $signed(want.center_x));
            if (rsp_center_y !== want.center_y)
               report_mismatch("center_y", rsp_center_y, $signed(want.center_y));
            if (rsp_center_z !== want.center_z)
               report_mismatch("center_z", rsp_center_z, $signed(want.center_z));
            if (rsp_span_smallest !== want.span_smallest)
               report_mismatch("span_smallest", rsp_span_smallest, want.span_smallest);
            if (rsp_span_largest !== want.span_largest)
               report_mismatch("span_largest", rsp_span_largest, want.span_largest);
         end
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", quiet_cycles);
         $display("magnetometer_calibration_session_grader_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   directed_row_type directed [21] = '{
      '{mcg_pkg::OP_SAMPLE, 5, 5, 5, 1, 0, mcg_pkg::PH_IDLE, 0},
      '{mcg_pkg::OP_CANCEL, 0, 0, 0, 1, 0, mcg_pkg::PH_IDLE, 0},
      '{OP_UNUSED, -1, -1, -1, 1, 0, mcg_pkg::PH_IDLE, 0},
      '{mcg_pkg::OP_START, 0, 0, 0, 1, 1, mcg_pkg::PH_RUN, 0},
      '{mcg_pkg::OP_START, 0, 0, 0, 1, 0, mcg_pkg::PH_RUN, 0},
      '{mcg_pkg::OP_SAMPLE, 32767, -32768, 0, 1, 1, mcg_pkg::PH_RUN, 1},
      '{mcg_pkg::OP_SAMPLE, -32768, 32767, -1, 1, 1, mcg_pkg::PH_RUN, 2},
      '{mcg_pkg::OP_SAMPLE, 0, 0, 32767, 1, 1, mcg_pkg::PH_RUN, 3},
      '{mcg_pkg::OP_SAMPLE, -1, 21845, -21846, 0, 0, mcg_pkg::PH_IDLE, 0},
      '{OP_UNUSED, 0, 0, 0, 1, 0, mcg_pkg::PH_RUN, 4},
      '{mcg_pkg::OP_CANCEL, 0, 0, 0, 1, 1, mcg_pkg::PH_CANCEL, 4},
      '{mcg_pkg::OP_SAMPLE, 100, 100, 100, 1, 0, mcg_pkg::PH_CANCEL, 4},
      '{mcg_pkg::OP_CANCEL, 0, 0, 0, 1, 0, mcg_pkg::PH_CANCEL, 4},
      '{OP_UNUSED, 0, 0, 0, 1, 0, mcg_pkg::PH_CANCEL, 4},
      '{mcg_pkg::OP_START, 0, 0, 0, 1, 1, mcg_pkg::PH_RUN, 0},
      '{mcg_pkg::OP_SAMPLE, -32768, -32768, -32768, 1, 1, mcg_pkg::PH_RUN, 1},
      '{mcg_pkg::OP_SAMPLE, -32767, -32768, 32767, 0, 0, mcg_pkg::PH_IDLE, 0},
      '{mcg_pkg::OP_SAMPLE, 1, 2, -3, 0, 0, mcg_pkg::PH_IDLE, 0},
      '{mcg_pkg::OP_SAMPLE, 21845, -21846, 0, 0, 0, mcg_pkg::PH_IDLE, 0},
      '{mcg_pkg::OP_CANCEL, 0, 0, 0, 1, 1, mcg_pkg::PH_CANCEL, 4},
      '{mcg_pkg::OP_START, 0, 0, 0, 1, 1, mcg_pkg::PH_RUN, 0}
   };

   initial begin
      int wait_cycles;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = mcg_pkg::OP_SAMPLE;
      req_sample_x = '0;
      req_sample_y = '0;
      req_sample_z = '0;
      csr_write = 1'b0;
      csr_index = mcg_pkg::CSR_S1;
      csr_data = '0;
      min_count = '{100, 300, 600};
      min_span = '{200, 400, 800};
      sess_phase = mcg_pkg::PH_IDLE;
      clear_envelope();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, on the reset thresholds.
      foreach (directed[i]) begin
         send_item(directed[i].op, directed[i].x, directed[i].y, directed[i].z,
                   directed[i].typed, directed[i].acc, directed[i].st, directed[i].cnt);
      end

      // Default thresholds: a long well-balanced session reaches readiness and grade three,
      // then a short squashed one; the long receiver hold-off falls inside the first.
      hold_results = 1'b1;
      run_session(650, 2500, 0);
      run_session(120, 600, 1);

      // Everything at zero: readiness then rests on the spans and octants alone; the unused
      // indexes must leave the thresholds alone.
      load_thresholds(0, 0, 0, 0, 0, 0);
      write_threshold(CSR_NONE, 20'hFFFFF);
      write_threshold(CSR_NONE_TOP, 20'hFFFFF);
      run_session(60, 300, 0);

      // Everything at the top: no grade is ever reached.
      load_thresholds(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_session(80, 3000, 0);

      // Modest random thresholds, several short sessions, some squashed so
      // that the balance terms drop readiness again.
      for (int k = 0; k < 4; k++) begin
         load_thresholds($urandom_range(1, 60), $urandom_range(40, 120),
                         $urandom_range(80, 200), $urandom_range(50, 600),
                         $urandom_range(100, 1200), $urandom_range(200, 2400));
         run_session($urandom_range(100, 150), $urandom_range(200, 2500), k[0]);
         run_session($urandom_range(20, 60), $urandom_range(50, 1500), 0);
      end

      // The closing stretch runs without any idling on either side.
      load_thresholds(100, 300, 600, 200, 400, 800);
      calm = 1'b1;
      run_session(150, 1500, 0);
      req_valid = 1'b0;

      wait_cycles = 0;
      while (pending_reports.size() != 0 && wait_cycles < 20 * WATCHDOG_LIMIT) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d items and %0d reports, %0d of them ready and %0d at grade three",
               items_sent, results_checked, ready_reports, grade_three_reports);
      $display("threshold sets: reset values, all zero, all full scale and random ones");
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("magnetometer_calibration_session_grader_core regression: pass");
      end else begin
         $display("%0d mismatches, %0d reports never arrived", errors, pending_reports.size());
         $display("magnetometer_calibration_session_grader_core regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/mcg_pkg.sv
sv/mcg_divider.sv
sv/magnetometer_calibration_session_grader_core.sv
dv/magnetometer_calibration_session_grader_core_tb.sv
